// ===== rtl/csem_pkg.sv =====
// ============================================================================
// csem_pkg: shared types and constants of the subexpression matcher
// Operator codes, fixed field widths, controller state type and the command
// and status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package csem_pkg;

    localparam int OP_W       = 4;
    localparam int SYM_PORT_W = 8;
    localparam int SLOT_W     = 5;

    localparam logic [OP_W-1:0] OP_COPY = 4'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } csem_state_t;

    // controller -> datapath
    typedef struct packed
    {
        logic load;    // latch the request, start a new scan
        logic step;    // advance the scan by one entry
        logic finish;  // emit the result, append it to the table if not full
    } csem_cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic hit;       // entry under compare matches the request
        logic scan_end;  // no stored entry left to read
    } csem_status_t;

endpackage

`default_nettype wire

// ===== rtl/csem_ram.sv =====
// ============================================================================
// csem_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ============================================================================
`default_nettype none

module csem_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/csem_ctrl.sv =====
// ============================================================================
// csem_ctrl: controller of the subexpression matcher
// Accept a request, drive the table scan, stop on the first match or at the
// end of the stored entries.
// ============================================================================
`default_nettype none

module csem_ctrl
    import csem_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire csem_status_t status,
    output csem_cmd_t         cmd,
    output logic              busy
);

    csem_state_t state_reg;
    csem_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // stop on the first match, or once nothing is left to read
                if (status.hit || status.scan_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/csem_dpath.sv =====
// ============================================================================
// csem_dpath: datapath of the subexpression matcher
// Hold the request, read stored entries one per cycle, compare, rewrite,
// append the emitted quadruple if the table has room, register the result.
// ============================================================================
`default_nettype none

module csem_dpath
    import csem_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int SYMBOL_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire csem_cmd_t             cmd,
    output csem_status_t               status,
    input  wire logic                  block_start,
    input  wire logic [OP_W-1:0]       op_code,
    input  wire logic [SYM_PORT_W-1:0] first_arg,
    input  wire logic [SYM_PORT_W-1:0] second_arg,
    input  wire logic [SYM_PORT_W-1:0] dest_symbol,
    output logic                       done,
    output logic      [OP_W-1:0]       out_op,
    output logic      [SYM_PORT_W-1:0] out_first,
    output logic      [SYM_PORT_W-1:0] out_second,
    output logic      [SYM_PORT_W-1:0] out_dest,
    output logic                       eliminated,
    output logic      [SLOT_W-1:0]     match_slot,
    output logic                       table_full
);

    localparam int SYM_W   = (SYMBOL_BITS < SYM_PORT_W) ? SYMBOL_BITS : SYM_PORT_W;
    localparam int ENTRY_W = OP_W + 3 * SYM_W;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // request under work
    logic [OP_W-1:0]  q_op_reg;
    logic [SYM_W-1:0] q_a_reg;
    logic [SYM_W-1:0] q_b_reg;
    logic [SYM_W-1:0] q_d_reg;

    // scan control
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] rd_idx_next;
    logic             cmp_valid_reg;
    logic             cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             done_reg;

    // result registers
    logic [OP_W-1:0]       out_op_reg;
    logic [SYM_PORT_W-1:0] out_first_reg;
    logic [SYM_PORT_W-1:0] out_second_reg;
    logic [SYM_PORT_W-1:0] out_dest_reg;
    logic                  elim_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  full_reg;

    logic               issue;
    logic               full;
    logic               commutes;
    logic               hit;
    logic [ENTRY_W-1:0] rd_data;
    logic [OP_W-1:0]    e_op;
    logic [SYM_W-1:0]   e_a;
    logic [SYM_W-1:0]   e_b;
    logic [SYM_W-1:0]   e_d;
    logic [OP_W-1:0]    w_op;
    logic [SYM_W-1:0]   w_a;
    logic [SYM_W-1:0]   w_b;

    assign issue = (rd_idx_reg < count_reg);
    assign full  = (count_reg == DEPTH_CNT);

    assign {e_op, e_a, e_b, e_d} = rd_data;

    assign commutes = (q_op_reg == OP_ADD) || (q_op_reg == OP_MUL);
    assign hit = cmp_valid_reg && (e_op == q_op_reg)
               && (((e_a == q_a_reg) && (e_b == q_b_reg))
                   || (commutes && (e_a == q_b_reg) && (e_b == q_a_reg)));

    assign status.hit      = hit;
    assign status.scan_end = !issue;

    // emitted form: copy of the earlier result on a match
    assign w_op = hit ? OP_COPY : q_op_reg;
    assign w_a  = hit ? e_d : q_a_reg;
    assign w_b  = hit ? '0 : q_b_reg;

    csem_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.finish && !full),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data ({w_op, w_a, w_b, q_d_reg}),
        .rd_en   (cmd.step && issue),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        if (cmd.load)
        begin
            count_next     = block_start ? '0 : count_reg;
            rd_idx_next    = '0;
            cmp_valid_next = 1'b0;
        end
        else if (cmd.step)
        begin
            rd_idx_next    = rd_idx_reg + CNT_W'(issue);
            cmp_valid_next = issue;
        end
        else if (cmd.finish)
        begin
            cmp_valid_next = 1'b0;
            if (!full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_op_reg <= op_code;
            q_a_reg  <= first_arg[SYM_W-1:0];
            q_b_reg  <= second_arg[SYM_W-1:0];
            q_d_reg  <= dest_symbol[SYM_W-1:0];
        end
        if (cmd.step)
        begin
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (cmd.finish)
        begin
            out_op_reg     <= w_op;
            out_first_reg  <= SYM_PORT_W'(w_a);
            out_second_reg <= SYM_PORT_W'(w_b);
            out_dest_reg   <= SYM_PORT_W'(q_d_reg);
            elim_reg       <= hit;
            slot_reg       <= hit ? SLOT_W'(cmp_idx_reg) : '0;
            full_reg       <= full;
        end
    end

    assign done       = done_reg;
    assign out_op     = out_op_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign out_dest   = out_dest_reg;
    assign eliminated = elim_reg;
    assign match_slot = slot_reg;
    assign table_full = full_reg;

endmodule

`default_nettype wire

// ===== rtl/common_subexpression_matcher.sv =====
// ============================================================================
// common_subexpression_matcher: local common-subexpression matcher
// Rewrites a quadruple as a copy when an equal expression is already stored
// in the current basic block, and adds what it emits to the table if not full.
// ============================================================================
//
// A request is taken on a clock edge with start high and busy low. The block
// then reads its stored entries one per cycle from a single-port-read table
// RAM, in storage order, and stops at the first entry with the same operator
// and arguments (swapped arguments also match for add and multiply). busy
// stays high until the scan ends: after the N entries stored before the
// request (N is 0 after block_start and at most TABLE_DEPTH), or when the
// first match is found. The time from one start to the next is thus set
// by the length of the scan. The result appears on the result ports,
// marked by done for exactly one cycle, in the first cycle with busy low
// after the request, and stays there until the next result; the
// receiver cannot hold it off, so capture it on that cycle. Every request
// gives exactly one result. When the table is full the request is still
// matched and answered, but it is not stored and table_full is set. The
// table needs no clearing after reset: only entries below the fill count are
// ever read.
//
`default_nettype none

module common_subexpression_matcher
    import csem_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int SYMBOL_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  block_start,
    input  wire logic [OP_W-1:0]       op_code,
    input  wire logic [SYM_PORT_W-1:0] first_arg,
    input  wire logic [SYM_PORT_W-1:0] second_arg,
    input  wire logic [SYM_PORT_W-1:0] dest_symbol,
    // result
    output logic                       done,
    output logic      [OP_W-1:0]       out_op,
    output logic      [SYM_PORT_W-1:0] out_first,
    output logic      [SYM_PORT_W-1:0] out_second,
    output logic      [SYM_PORT_W-1:0] out_dest,
    output logic                       eliminated,
    output logic      [SLOT_W-1:0]     match_slot,
    output logic                       table_full
);

    csem_cmd_t    cmd;
    csem_status_t status;

    // sequencing: accept, scan, emit
    csem_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // table, compare, rewrite and result registers
    csem_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .block_start (block_start),
        .op_code     (op_code),
        .first_arg   (first_arg),
        .second_arg  (second_arg),
        .dest_symbol (dest_symbol),
        .done        (done),
        .out_op      (out_op),
        .out_first   (out_first),
        .out_second  (out_second),
        .out_dest    (out_dest),
        .eliminated  (eliminated),
        .match_slot  (match_slot),
        .table_full  (table_full)
    );

endmodule

`default_nettype wire

// ===== rtl/csem_checker.sv =====
// ============================================================================
// csem_checker: port-level checks of the subexpression matcher
// Watch the request and result ports and flag sequencing or rewrite slips.
// ============================================================================
`default_nettype none

module csem_checker
    import csem_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  done,
    input wire logic [OP_W-1:0]       out_op,
    input wire logic [SYM_PORT_W-1:0] out_second,
    input wire logic                  eliminated,
    input wire logic [SLOT_W-1:0]     match_slot
);

    // an accepted request always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but busy not raised");

    // a result only ever ends a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in progress");

    // one result per request: done is a strobe and never stays high
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // an eliminated quadruple is a plain copy
    a_elim_copy: assert property (@(posedge clk) disable iff (!rst_n)
        done && eliminated |-> (out_op == OP_COPY) && (out_second == '0))
        else $error("eliminated result not rewritten as a copy");

    // no slot reported without a match
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !eliminated |-> (match_slot == '0))
        else $error("match slot set without a match");

endmodule

bind common_subexpression_matcher csem_checker u_csem_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .out_op     (out_op),
    .out_second (out_second),
    .eliminated (eliminated),
    .match_slot (match_slot)
);

`default_nettype wire
